// ===== rtl/fba_pkg.sv =====
// Shared types and constants of the frame bitmap allocator.
package fba_pkg;

   localparam int NUM_FRAMES_DEF = 4096;
   localparam int WORD_BITS_DEF  = 32;

   // The frame number field is 12 bits, so only the first 4096 frames are reachable.
   localparam int FRAME_W      = 12;
   localparam int FIELD_FRAMES = 4096;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOOP    = 2'd1,
      ST_NO_FREE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_DIV,
      S_FREE_RD,
      S_FREE_WR
   } state_type;

endpackage

// ===== rtl/frame_bitmap_allocator.sv =====
// First-fit page frame allocator over a used/free bitmap held in block memory.
// A no-op request is answered straight from idle; a free passes the split, read and write
// states; an allocate scans words until it finds a free frame or has checked the last word.
// Throughput: one request at a time; the next start is taken in the cycle the word shows.
// The scan reads one bitmap word per cycle through the single RAM read port.
// Reset: a clearing pass writes every bitmap word to zero, with busy held high.
module frame_bitmap_allocator #(
   parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF,
   parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_type,
   input  logic [fba_pkg::FRAME_W-1:0] req_current_frame,
   input  logic                        req_is_kernel,
   input  logic                        req_is_writeable,
   output logic                        rsp_valid,
   output logic [fba_pkg::FRAME_W-1:0] rsp_frame_number,
   output logic                        rsp_present_flag,
   output logic                        rsp_rw_flag,
   output logic                        rsp_user_flag,
   output logic [1:0]                  rsp_status
);

   localparam int LIMIT = (NUM_FRAMES < fba_pkg::FIELD_FRAMES) ? NUM_FRAMES
                                                               : fba_pkg::FIELD_FRAMES;
   localparam int WORDS     = (LIMIT + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int LAST_BITS = LIMIT - (WORDS - 1) * WORD_BITS;
   localparam logic [ADDR_W-1:0]    LAST_IDX = ADDR_W'(WORDS - 1);
   localparam logic [WORD_BITS-1:0] ONE_W    = WORD_BITS'(1);
   // frames past the search limit in the last word read as used
   localparam logic [WORD_BITS-1:0] PAD_MASK = ~((ONE_W << LAST_BITS) - ONE_W);

   fba_pkg::state_type state_ff, state_in;

   logic [ADDR_W-1:0]           clr_idx_ff, clr_idx_in;
   logic [ADDR_W-1:0]           issue_idx_ff, issue_idx_in;
   logic                        issue_vld_ff, issue_vld_in;
   logic [ADDR_W-1:0]           chk_idx_ff, chk_idx_in;
   logic                        chk_vld_ff, chk_vld_in;
   logic [ADDR_W-1:0]           fw_idx_ff, fw_idx_in;
   logic [BIT_W-1:0]            fb_idx_ff, fb_idx_in;
   logic [fba_pkg::FRAME_W-1:0] cur_ff, cur_in;
   logic                        kern_ff, kern_in;
   logic                        wr_ff, wr_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [fba_pkg::FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic                        rsp_present_ff, rsp_present_in;
   logic                        rsp_rw_ff, rsp_rw_in;
   logic                        rsp_user_ff, rsp_user_in;
   fba_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [WORD_BITS-1:0] mem_rdata;

   logic [WORD_BITS-1:0] scan_word;
   logic                 scan_found;
   logic [BIT_W-1:0]     scan_bit;
   logic [WORD_BITS-1:0] scan_set_word;
   logic [ADDR_W-1:0]    split_word;
   logic [BIT_W-1:0]     split_bit;
   logic                 accept;
   logic                 free_in_range;

   fba_bitmap_ram #(
      .DEPTH  (WORDS),
      .WIDTH  (WORD_BITS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign scan_word = (chk_idx_ff == LAST_IDX) ? (mem_rdata | PAD_MASK) : mem_rdata;

   fba_free_bit_find #(
      .WORD_BITS (WORD_BITS),
      .BIT_W     (BIT_W)
   ) u_find (
      .word_i     (scan_word),
      .found_o    (scan_found),
      .bit_o      (scan_bit),
      .set_word_o (scan_set_word)
   );

   fba_frame_split #(
      .WORD_BITS (WORD_BITS),
      .ADDR_W    (ADDR_W),
      .BIT_W     (BIT_W)
   ) u_split (
      .clock   (clock),
      .frame_i (cur_ff),
      .word_o  (split_word),
      .bit_o   (split_bit)
   );

   assign accept        = start && !busy;
   assign free_in_range = (req_current_frame != '0) && (int'(req_current_frame) < NUM_FRAMES);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fba_pkg::S_CLEAR: begin
            if (clr_idx_ff == LAST_IDX) begin
               state_in = fba_pkg::S_IDLE;
            end
         end
         fba_pkg::S_IDLE: begin
            if (start) begin
               if (req_type == fba_pkg::REQ_FREE) begin
                  if (free_in_range) begin
                     state_in = fba_pkg::S_FREE_DIV;
                  end
               end else if (req_current_frame == '0) begin
                  state_in = fba_pkg::S_SCAN;
               end
            end
         end
         fba_pkg::S_SCAN: begin
            if (chk_vld_ff && (scan_found || chk_idx_ff == LAST_IDX)) begin
               state_in = fba_pkg::S_IDLE;
            end
         end
         fba_pkg::S_FREE_DIV: state_in = fba_pkg::S_FREE_RD;
         fba_pkg::S_FREE_RD:  state_in = fba_pkg::S_FREE_WR;
         fba_pkg::S_FREE_WR:  state_in = fba_pkg::S_IDLE;
         default:             state_in = fba_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      busy           = (state_ff != fba_pkg::S_IDLE);
      mem_we         = 1'b0;
      mem_waddr      = clr_idx_ff;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = issue_idx_ff;
      clr_idx_in     = clr_idx_ff;
      issue_idx_in   = issue_idx_ff;
      issue_vld_in   = issue_vld_ff;
      chk_idx_in     = chk_idx_ff;
      chk_vld_in     = chk_vld_ff;
      fw_idx_in      = fw_idx_ff;
      fb_idx_in      = fb_idx_ff;
      cur_in         = cur_ff;
      kern_in        = kern_ff;
      wr_in          = wr_ff;
      rsp_valid_in   = 1'b0;
      rsp_frame_in   = rsp_frame_ff;
      rsp_present_in = rsp_present_ff;
      rsp_rw_in      = rsp_rw_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_status_in  = rsp_status_ff;
      case (state_ff)
         fba_pkg::S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = '0;
            if (clr_idx_ff != LAST_IDX) begin
               clr_idx_in = clr_idx_ff + ADDR_W'(1);
            end
         end
         fba_pkg::S_IDLE: begin
            if (accept) begin
               cur_in         = req_current_frame;
               kern_in        = req_is_kernel;
               wr_in          = req_is_writeable;
               rsp_present_in = 1'b0;
               rsp_rw_in      = 1'b0;
               rsp_user_in    = 1'b0;
               if (req_type == fba_pkg::REQ_FREE) begin
                  if (!free_in_range) begin
                     // nothing to free, or frame beyond the map: echo it back
                     rsp_valid_in  = 1'b1;
                     rsp_frame_in  = req_current_frame;
                     rsp_status_in = fba_pkg::ST_NOOP;
                  end
               end else if (req_current_frame != '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_frame_in  = req_current_frame;
                  rsp_status_in = fba_pkg::ST_NOOP;
               end else begin
                  issue_idx_in = '0;
                  issue_vld_in = 1'b1;
                  chk_vld_in   = 1'b0;
               end
            end
         end
         fba_pkg::S_SCAN: begin
            mem_re     = issue_vld_ff;
            mem_raddr  = issue_idx_ff;
            chk_idx_in = issue_idx_ff;
            chk_vld_in = issue_vld_ff;
            if (issue_vld_ff) begin
               if (issue_idx_ff == LAST_IDX) begin
                  issue_vld_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + ADDR_W'(1);
               end
            end
            if (chk_vld_ff) begin
               if (scan_found) begin
                  mem_we         = 1'b1;
                  mem_waddr      = chk_idx_ff;
                  mem_wdata      = scan_set_word;
                  rsp_valid_in   = 1'b1;
                  rsp_frame_in   = fba_pkg::FRAME_W'(int'(chk_idx_ff) * WORD_BITS
                                                     + int'(scan_bit));
                  rsp_present_in = 1'b1;
                  rsp_rw_in      = wr_ff;
                  rsp_user_in    = kern_ff;
                  rsp_status_in  = fba_pkg::ST_DONE;
               end else if (chk_idx_ff == LAST_IDX) begin
                  rsp_valid_in   = 1'b1;
                  rsp_frame_in   = '0;
                  rsp_present_in = 1'b0;
                  rsp_rw_in      = 1'b0;
                  rsp_user_in    = 1'b0;
                  rsp_status_in  = fba_pkg::ST_NO_FREE;
               end
            end
         end
         fba_pkg::S_FREE_DIV: begin
            // split unit registers its quotient estimate this cycle
         end
         fba_pkg::S_FREE_RD: begin
            mem_re    = 1'b1;
            mem_raddr = split_word;
            fw_idx_in = split_word;
            fb_idx_in = split_bit;
         end
         fba_pkg::S_FREE_WR: begin
            mem_we        = 1'b1;
            mem_waddr     = fw_idx_ff;
            mem_wdata     = mem_rdata & ~(ONE_W << fb_idx_ff);
            rsp_valid_in  = 1'b1;
            rsp_frame_in  = '0;
            rsp_status_in = fba_pkg::ST_DONE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fba_pkg::S_CLEAR;
         clr_idx_ff   <= '0;
         issue_vld_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         issue_vld_ff <= issue_vld_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff   <= issue_idx_in;
      chk_idx_ff     <= chk_idx_in;
      fw_idx_ff      <= fw_idx_in;
      fb_idx_ff      <= fb_idx_in;
      cur_ff         <= cur_in;
      kern_ff        <= kern_in;
      wr_ff          <= wr_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_present_ff <= rsp_present_in;
      rsp_rw_ff      <= rsp_rw_in;
      rsp_user_ff    <= rsp_user_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_present_flag = rsp_present_ff;
   assign rsp_rw_flag      = rsp_rw_ff;
   assign rsp_user_flag    = rsp_user_ff;
   assign rsp_status       = rsp_status_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == fba_pkg::S_IDLE |-> !mem_we)
      else $error("bitmap written while idle");

   a_free_none_noop: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == fba_pkg::REQ_FREE && req_current_frame == '0
      |=> rsp_valid && rsp_status == fba_pkg::ST_NOOP)
      else $error("free of no frame did not answer as no-op next cycle");

   a_present_means_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_present_flag |-> rsp_status == fba_pkg::ST_DONE)
      else $error("present flag on a failed or no-op word");

   a_scan_word_stale: assert property (@(posedge clock) disable iff (reset)
      state_ff == fba_pkg::S_SCAN && chk_vld_ff |-> $past(mem_re) && $past(issue_vld_ff))
      else $error("scan checked a word that was never read");

   a_rsp_ends_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == fba_pkg::S_IDLE)
      else $error("result word shown while still working");

endmodule

// ===== rtl/fba_bitmap_ram.sv =====
// Used/free bitmap storage: one write port, one read port with registered data.
module fba_bitmap_ram #(
   parameter int DEPTH  = 128,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fba_free_bit_find.sv =====
// Lowest clear bit of a bitmap word: presence, position and the word with it set.
module fba_free_bit_find #(
   parameter int WORD_BITS = 32,
   parameter int BIT_W     = 5
) (
   input  logic [WORD_BITS-1:0] word_i,
   output logic                 found_o,
   output logic [BIT_W-1:0]     bit_o,
   output logic [WORD_BITS-1:0] set_word_o
);

   logic [WORD_BITS-1:0] low_clear;
   logic [BIT_W-1:0]     idx;

   // isolate the lowest zero: one-hot, or zero when the word is full
   assign low_clear = ~word_i & (word_i + WORD_BITS'(1));

   always_comb begin
      idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_clear[i]) begin
            idx = idx | BIT_W'(i);
         end
      end
   end

   assign found_o    = |low_clear;
   assign bit_o      = idx;
   assign set_word_o = word_i | low_clear;

endmodule

// ===== rtl/fba_frame_split.sv =====
// Splits a frame number into bitmap word index and bit position (reciprocal multiply).
module fba_frame_split #(
   parameter int WORD_BITS = 32,
   parameter int ADDR_W    = 7,
   parameter int BIT_W     = 5
) (
   input  logic                        clock,
   input  logic [fba_pkg::FRAME_W-1:0] frame_i,
   output logic [ADDR_W-1:0]           word_o,
   output logic [BIT_W-1:0]            bit_o
);

   localparam int SHIFT   = 20;
   localparam int RECIP_W = SHIFT + 1 - $clog2(WORD_BITS);
   localparam int PROD_W  = fba_pkg::FRAME_W + RECIP_W;
   localparam int REM_W   = fba_pkg::FRAME_W + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SHIFT) / WORD_BITS);

   logic [PROD_W-1:0]           prod;
   logic [fba_pkg::FRAME_W-1:0] qest_ff;
   logic [fba_pkg::FRAME_W-1:0] qest_in;
   logic [REM_W-1:0]            rem;
   logic                        wrap;

   // quotient estimate is exact or one short; one compare fixes it
   assign prod    = PROD_W'(frame_i) * PROD_W'(RECIP);
   assign qest_in = fba_pkg::FRAME_W'(prod >> SHIFT);

   always_ff @(posedge clock) begin
      qest_ff <= qest_in;
   end

   assign rem  = REM_W'(frame_i) - REM_W'(int'(qest_ff) * WORD_BITS);
   assign wrap = rem >= REM_W'(WORD_BITS);

   assign bit_o  = wrap ? BIT_W'(rem - REM_W'(WORD_BITS)) : BIT_W'(rem);
   assign word_o = ADDR_W'(qest_ff + fba_pkg::FRAME_W'(wrap));

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the frame bitmap allocator: directed and random alloc/free words.
module tb;

   localparam int NUM_FRAMES   = fba_pkg::NUM_FRAMES_DEF;
   localparam int WORD_BITS    = fba_pkg::WORD_BITS_DEF;
   localparam int WORD_COUNT   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int SEARCH_LIMIT = (NUM_FRAMES < fba_pkg::FIELD_FRAMES) ? NUM_FRAMES
                                                                      : fba_pkg::FIELD_FRAMES;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int DRAIN_CYCLES = 140;

   typedef struct packed {
      logic [fba_pkg::FRAME_W-1:0] frame;
      logic                        present;
      logic                        rw;
      logic                        user;
      fba_pkg::status_type         status;
   } page_entry_type;

   class alloc_scoreboard_type;
      bit [WORD_BITS-1:0] used_map [WORD_COUNT];
      page_entry_type     expected_words[$];
      int unsigned        errors;

      task report(string msg);
         errors++;
         if (errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      // First-fit update of the bitmap; returns the entry the block should hand back.
      function page_entry_type note_request(fba_pkg::req_kind_type kind,
                                            logic [fba_pkg::FRAME_W-1:0] cur,
                                            logic kern, logic wr);
         page_entry_type e;
         bit             found;
         int             f;
         e = '{frame: '0, present: 1'b0, rw: 1'b0, user: 1'b0, status: fba_pkg::ST_DONE};
         if (kind == fba_pkg::REQ_ALLOC) begin
            if (cur != 0) begin
               e.frame  = cur;
               e.status = fba_pkg::ST_NOOP;
            end else begin
               found = 1'b0;
               for (f = 0; f < SEARCH_LIMIT && !found; f++) begin
                  if (!used_map[f / WORD_BITS][f % WORD_BITS]) begin
                     found = 1'b1;
                     used_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
                     e.frame   = fba_pkg::FRAME_W'(f);
                     e.present = 1'b1;
                     e.rw      = wr;
                     e.user    = kern;
                  end
               end
               if (!found) e.status = fba_pkg::ST_NO_FREE;
            end
         end else begin
            if (cur == 0) begin
               e.status = fba_pkg::ST_NOOP;
            end else if (cur >= NUM_FRAMES) begin
               e.frame  = cur;
               e.status = fba_pkg::ST_NOOP;
            end else begin
               used_map[cur / WORD_BITS][cur % WORD_BITS] = 1'b0;
            end
         end
         expected_words.push_back(e);
         return e;
      endfunction

      task check_response(page_entry_type got);
         page_entry_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word frame %0d status %0d", got.frame, got.status));
            return;
         end
         want = expected_words.pop_front();
         if (got.frame !== want.frame)
            report($sformatf("frame_number %0d, want %0d", got.frame, want.frame));
         if (got.present !== want.present)
            report($sformatf("present_flag %b, want %b", got.present, want.present));
         if (got.rw !== want.rw)
            report($sformatf("rw_flag %b, want %b", got.rw, want.rw));
         if (got.user !== want.user)
            report($sformatf("user_flag %b, want %b", got.user, want.user));
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_type;
   logic [fba_pkg::FRAME_W-1:0] req_current_frame;
   logic                        req_is_kernel;
   logic                        req_is_writeable;
   logic                        rsp_valid;
   logic [fba_pkg::FRAME_W-1:0] rsp_frame_number;
   logic                        rsp_present_flag;
   logic                        rsp_rw_flag;
   logic                        rsp_user_flag;
   logic [1:0]                  rsp_status;

   alloc_scoreboard_type        sb = new();
   logic [fba_pkg::FRAME_W-1:0] held_frames[$];
   bit                          gaps_on = 1'b1;
   bit                          quiet_tail = 1'b0;
   int unsigned                 cycle_count = 0;

   frame_bitmap_allocator #(
      .NUM_FRAMES(NUM_FRAMES),
      .WORD_BITS (WORD_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_current_frame(req_current_frame),
      .req_is_kernel    (req_is_kernel),
      .req_is_writeable (req_is_writeable),
      .rsp_valid        (rsp_valid),
      .rsp_frame_number (rsp_frame_number),
      .rsp_present_flag (rsp_present_flag),
      .rsp_rw_flag      (rsp_rw_flag),
      .rsp_user_flag    (rsp_user_flag),
      .rsp_status       (rsp_status)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL frame_bitmap_allocator");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_valid === 1'b1)
         sb.check_response('{frame: rsp_frame_number, present: rsp_present_flag,
                             rw: rsp_rw_flag, user: rsp_user_flag,
                             status: fba_pkg::status_type'(rsp_status)});
   end

   // Holds start high until the word is taken, then maybe leaves a short gap.
   task automatic send_request(input fba_pkg::req_kind_type kind,
                               input logic [fba_pkg::FRAME_W-1:0] cur,
                               input logic kern, input logic wr);
      page_entry_type want;
      start             <= 1'b1;
      req_type          <= kind;
      req_current_frame <= cur;
      req_is_kernel     <= kern;
      req_is_writeable  <= wr;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      want = sb.note_request(kind, cur, kern, wr);
      if (kind == fba_pkg::REQ_ALLOC && want.status == fba_pkg::ST_DONE && want.frame != 0)
         held_frames.push_back(want.frame);
      if (gaps_on && $urandom_range(2) == 0) begin
         start             <= 1'b0;
         req_type          <= 1'($urandom_range(1));
         req_current_frame <= fba_pkg::FRAME_W'($urandom_range(4095));
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      if (!quiet_tail && $urandom_range(39) == 0) gaps_on = !gaps_on;
   endtask

   task automatic random_request(input int alloc_pct, input int free_pct);
      int                          r;
      int                          idx;
      logic [fba_pkg::FRAME_W-1:0] cur;
      r   = $urandom_range(99);
      cur = fba_pkg::FRAME_W'($urandom_range(4095));
      if (r < alloc_pct) begin
         send_request(fba_pkg::REQ_ALLOC, '0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (r < alloc_pct + 8) begin
         send_request(fba_pkg::REQ_ALLOC, cur, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (r < alloc_pct + 8 + free_pct && held_frames.size() != 0) begin
         idx = $urandom_range(held_frames.size() - 1);
         cur = held_frames[idx];
         held_frames.delete(idx);
         send_request(fba_pkg::REQ_FREE, cur, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
         if ($urandom_range(9) == 0) cur = '0;
         send_request(fba_pkg::REQ_FREE, cur, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      int n;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_type          <= fba_pkg::REQ_ALLOC;
      req_current_frame <= '0;
      req_is_kernel     <= 1'b0;
      req_is_writeable  <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // frame zero is handed out first, then flag combinations
      send_request(fba_pkg::REQ_ALLOC, '0, 1'b0, 1'b0);
      send_request(fba_pkg::REQ_ALLOC, '0, 1'b1, 1'b1);
      send_request(fba_pkg::REQ_ALLOC, '0, 1'b1, 1'b0);
      send_request(fba_pkg::REQ_ALLOC, '0, 1'b0, 1'b1);
      // entry already holds a frame
      send_request(fba_pkg::REQ_ALLOC, 12'hFFF, 1'b1, 1'b1);
      send_request(fba_pkg::REQ_ALLOC, 12'h001, 1'b1, 1'b1);
      send_request(fba_pkg::REQ_ALLOC, 12'hAAA, 1'b0, 1'b1);
      send_request(fba_pkg::REQ_ALLOC, 12'h555, 1'b1, 1'b0);
      // nothing to free, frees of used and of clear bits, and reuse of freed frames
      send_request(fba_pkg::REQ_FREE, '0, 1'b1, 1'b1);
      send_request(fba_pkg::REQ_FREE, 12'hFFF, 1'b1, 1'b1);
      send_request(fba_pkg::REQ_FREE, 12'h002, 1'b0, 1'b0);
      send_request(fba_pkg::REQ_FREE, 12'h002, 1'b1, 1'b0);
      send_request(fba_pkg::REQ_ALLOC, '0, 1'b1, 1'b1);
      send_request(fba_pkg::REQ_FREE, 12'h001, 1'b0, 1'b1);
      send_request(fba_pkg::REQ_FREE, 12'h003, 1'b1, 1'b1);
      send_request(fba_pkg::REQ_ALLOC, '0, 1'b0, 1'b0);
      send_request(fba_pkg::REQ_ALLOC, '0, 1'b1, 1'b1);
      send_request(fba_pkg::REQ_ALLOC, '0, 1'b0, 1'b1);
      send_request(fba_pkg::REQ_FREE, 12'h800, 1'b0, 1'b0);

      for (n = 0; n < 600; n++) random_request(65, 20);

      // grow the bitmap so the later scans walk many words
      repeat (400)
         send_request(fba_pkg::REQ_ALLOC, '0, 1'($urandom_range(1)), 1'($urandom_range(1)));

      for (n = 0; n < 430; n++) begin
         if (n == 330) begin
            quiet_tail = 1'b1;
            gaps_on    = 1'b0;
         end
         random_request(45, 35);
      end
      start <= 1'b0;

      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_words.size() != 0)
         sb.report($sformatf("%0d words never arrived", sb.expected_words.size()));
      if (sb.errors == 0)
         $display("PASS frame_bitmap_allocator");
      else
         $display("FAIL frame_bitmap_allocator");
      $finish;
   end

endmodule

// ===== frame_bitmap_allocator.f =====
rtl/fba_pkg.sv
rtl/fba_bitmap_ram.sv
rtl/fba_free_bit_find.sv
rtl/fba_frame_split.sv
rtl/frame_bitmap_allocator.sv
bench/tb.sv
